@@ rtl/core/iapm_pkg.sv @@
// shared types and constants for the inverse affine pixel mapper
package iapm_pkg;

    // field widths
    localparam int C_COORD_W = 16;
    localparam int C_COEF_W  = 32;
    localparam int C_DIM_REG_W = 13;
    localparam int C_ADDR_W  = 26;
    localparam int C_CFG_IDX_W = 3;

    // datapath widths
    localparam int C_CEN_W = 34;    // centered coordinate, q16.16 with headroom
    localparam int C_HI_W  = C_CEN_W - 16;
    localparam int C_PH_W  = C_COEF_W + C_HI_W;
    localparam int C_PL_W  = C_COEF_W + 17;
    localparam int C_SH_W  = C_PH_W + 1;
    localparam int C_SL_W  = C_PL_W + 1;
    localparam int C_V_W   = 68;

    localparam int C_BYTES_PER_PX = 3;

    // register reset values
    localparam logic signed [C_COEF_W-1:0] C_ONE_Q16 = 32'sh0001_0000;
    localparam logic [C_DIM_REG_W-1:0] C_DIM_RST = 13'd4096;

    typedef enum logic [C_CFG_IDX_W-1:0] {
        CFG_M00    = 3'd0,
        CFG_M01    = 3'd1,
        CFG_M10    = 3'd2,
        CFG_M11    = 3'd3,
        CFG_SHIFTX = 3'd4,
        CFG_SHIFTY = 3'd5,
        CFG_WIDTH  = 3'd6,
        CFG_HEIGHT = 3'd7
    } t_cfg_idx;

endpackage

@@ rtl/core/iapm_in_if.sv @@
// destination coordinate channel
interface iapm_in_if import iapm_pkg::*; ();
    logic                        valid;
    logic                        ready;
    logic signed [C_COORD_W-1:0] dest_x;
    logic signed [C_COORD_W-1:0] dest_y;

    modport source (output valid, output dest_x, output dest_y, input ready);
    modport sink   (input valid, input dest_x, input dest_y, output ready);
endinterface

@@ rtl/core/iapm_out_if.sv @@
// mapped source pixel channel
interface iapm_out_if import iapm_pkg::*; ();
    logic                        valid;
    logic                        ready;
    logic signed [C_COORD_W-1:0] src_x;
    logic signed [C_COORD_W-1:0] src_y;
    logic                        inside_res;
    logic [C_ADDR_W-1:0]         byte_address;

    modport source (output valid, output src_x, output src_y, output inside_res,
                    output byte_address, input ready);
    modport sink   (input valid, input src_x, input src_y, input inside_res,
                    input byte_address, output ready);
endinterface

@@ rtl/core/inverse_affine_pixel_mapper_unit.sv @@
// inverse affine pixel mapper: destination pixel to source pixel and rgb address
// throughput: one transaction per cycle while the output is accepted; each stage holds its item under back-pressure
// and takes a new one as soon as its successor frees, so bubbles are squeezed out
// reset (synchronous, active low) empties all stages and restores identity matrix,
// zero shift and 4096 x 4096 image; no clearing pass is needed
module inverse_affine_pixel_mapper_unit import iapm_pkg::*; #(
    parameter int MAX_DIM = 4096
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [C_CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [C_COEF_W-1:0]    i_cfg_data,
    iapm_in_if.sink                i_pix,
    iapm_out_if.source             o_pix
);

    localparam int DIM_W  = $clog2(MAX_DIM + 1);
    localparam int LIN_W  = 2 * DIM_W;
    localparam int PAD_W  = C_CEN_W - DIM_W - 15;
    localparam int NSTG   = 7;

    // configuration registers
    logic signed [C_COEF_W-1:0] r_m00, r_m01, r_m10, r_m11;
    logic signed [C_COEF_W-1:0] r_shift_x, r_shift_y;
    logic [C_DIM_REG_W-1:0]     r_width, r_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m00     <= C_ONE_Q16;
            r_m01     <= '0;
            r_m10     <= '0;
            r_m11     <= C_ONE_Q16;
            r_shift_x <= '0;
            r_shift_y <= '0;
            r_width   <= C_DIM_RST;
            r_height  <= C_DIM_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_M00:    r_m00     <= $signed(i_cfg_data);
                CFG_M01:    r_m01     <= $signed(i_cfg_data);
                CFG_M10:    r_m10     <= $signed(i_cfg_data);
                CFG_M11:    r_m11     <= $signed(i_cfg_data);
                CFG_SHIFTX: r_shift_x <= $signed(i_cfg_data);
                CFG_SHIFTY: r_shift_y <= $signed(i_cfg_data);
                CFG_WIDTH:  r_width   <= i_cfg_data[C_DIM_REG_W-1:0];
                CFG_HEIGHT: r_height  <= i_cfg_data[C_DIM_REG_W-1:0];
                default: ;
            endcase
        end
    end

    // effective dimensions, clamped to the largest supported image
    logic [DIM_W-1:0] w_eff, h_eff;

    always_comb begin
        w_eff = (32'(r_width) > 32'(MAX_DIM)) ? DIM_W'(MAX_DIM) : DIM_W'(r_width);
        h_eff = (32'(r_height) > 32'(MAX_DIM)) ? DIM_W'(MAX_DIM) : DIM_W'(r_height);
    end

    // per-stage valid bits and stage enables; a stage loads when it is empty
    // or its successor loads in the same cycle
    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] en;

    always_comb begin
        en[NSTG-1] = !r_vld[NSTG-1] || o_pix.ready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    assign i_pix.ready = en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) begin
                r_vld[0] <= i_pix.valid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // stage 0: center on the image and add the inverse translation (q16.16)
    logic signed [C_CEN_W-1:0] n_cx, n_cy, r_cx, r_cy;

    always_comb begin
        n_cx = $signed({{2{i_pix.dest_x[C_COORD_W-1]}}, i_pix.dest_x, 16'h0000})
             - $signed({{PAD_W{1'b0}}, w_eff, 15'h0000})
             + $signed({{2{r_shift_x[C_COEF_W-1]}}, r_shift_x});
        n_cy = $signed({{2{i_pix.dest_y[C_COORD_W-1]}}, i_pix.dest_y, 16'h0000})
             - $signed({{PAD_W{1'b0}}, h_eff, 15'h0000})
             + $signed({{2{r_shift_y[C_COEF_W-1]}}, r_shift_y});
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_cx <= n_cx;
            r_cy <= n_cy;
        end
    end

    // stage 1: partial products, coordinate split into a floored high half
    // and an unsigned 16-bit fraction so each multiplier stays near 32 x 18
    logic signed [C_HI_W-1:0] cxh, cyh;
    logic signed [16:0]       cxl, cyl;
    logic signed [C_PH_W-1:0] r_p00h, r_p01h, r_p10h, r_p11h;
    logic signed [C_PL_W-1:0] r_p00l, r_p01l, r_p10l, r_p11l;

    assign cxh = r_cx[C_CEN_W-1:16];
    assign cyh = r_cy[C_CEN_W-1:16];
    assign cxl = $signed({1'b0, r_cx[15:0]});
    assign cyl = $signed({1'b0, r_cy[15:0]});

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r_p00h <= r_m00 * cxh;
            r_p01h <= r_m01 * cyh;
            r_p10h <= r_m10 * cxh;
            r_p11h <= r_m11 * cyh;
            r_p00l <= r_m00 * cxl;
            r_p01l <= r_m01 * cyl;
            r_p10l <= r_m10 * cxl;
            r_p11l <= r_m11 * cyl;
        end
    end

    // stage 2: sum the high and low partial products per axis
    logic signed [C_SH_W-1:0] r_shx, r_shy;
    logic signed [C_SL_W-1:0] r_slx, r_sly;

    always_ff @(posedge i_clk) begin
        if (en[2]) begin
            r_shx <= C_SH_W'(r_p00h) + C_SH_W'(r_p01h);
            r_shy <= C_SH_W'(r_p10h) + C_SH_W'(r_p11h);
            r_slx <= C_SL_W'(r_p00l) + C_SL_W'(r_p01l);
            r_sly <= C_SL_W'(r_p10l) + C_SL_W'(r_p11l);
        end
    end

    // stage 3: recombine into the exact q36.32 value plus half the image size
    logic signed [C_V_W-1:0] r_vx, r_vy;

    always_ff @(posedge i_clk) begin
        if (en[3]) begin
            r_vx <= (C_V_W'(r_shx) <<< 16) + C_V_W'(r_slx)
                  + $signed(C_V_W'({w_eff, 31'h0}));
            r_vy <= (C_V_W'(r_shy) <<< 16) + C_V_W'(r_sly)
                  + $signed(C_V_W'({h_eff, 31'h0}));
        end
    end

    // stage 4: truncate toward zero and saturate to 16 bits
    function automatic logic signed [C_COORD_W-1:0] trunc_sat(
        input logic signed [C_V_W-1:0] v
    );
        logic signed [C_V_W-1:0]  vb;
        logic signed [C_V_W-33:0] q;
        // negative values get a bias so the arithmetic shift rounds up
        vb = v[C_V_W-1] ? v + C_V_W'(33'h0_FFFF_FFFF) : v;
        q  = vb[C_V_W-1:32];
        if (q > (C_V_W-32)'(32767)) begin
            trunc_sat = 16'sh7FFF;
        end else if (q < -(C_V_W-32)'(32768)) begin
            trunc_sat = 16'sh8000;
        end else begin
            trunc_sat = q[C_COORD_W-1:0];
        end
    endfunction

    logic signed [C_COORD_W-1:0] r_sx4, r_sy4;

    always_ff @(posedge i_clk) begin
        if (en[4]) begin
            r_sx4 <= trunc_sat(r_vx);
            r_sy4 <= trunc_sat(r_vy);
        end
    end

    // stage 5: bounds check and linear pixel index y * width + x
    logic signed [C_COORD_W-1:0] r_sx5, r_sy5;
    logic                        r_in5;
    logic [LIN_W-1:0]            r_lin;
    logic                        n_in5;

    always_comb begin
        n_in5 = !r_sx4[C_COORD_W-1] && (32'(r_sx4[C_COORD_W-2:0]) < 32'(w_eff))
             && !r_sy4[C_COORD_W-1] && (32'(r_sy4[C_COORD_W-2:0]) < 32'(h_eff));
    end

    always_ff @(posedge i_clk) begin
        if (en[5]) begin
            r_sx5 <= r_sx4;
            r_sy5 <= r_sy4;
            r_in5 <= n_in5;
            // only meaningful when inside, masked in the next stage otherwise
            r_lin <= LIN_W'(r_sy4[DIM_W-1:0]) * LIN_W'(w_eff) + LIN_W'(r_sx4[DIM_W-1:0]);
        end
    end

    // stage 6: output register, rgb byte address
    logic [LIN_W+1:0] lin3;

    assign lin3 = (LIN_W+2)'(r_lin) * (LIN_W+2)'(C_BYTES_PER_PX);

    always_ff @(posedge i_clk) begin
        if (en[6]) begin
            o_pix.src_x        <= r_sx5;
            o_pix.src_y        <= r_sy5;
            o_pix.inside_res   <= r_in5;
            o_pix.byte_address <= r_in5 ? C_ADDR_W'(lin3) : '0;
        end
    end

    assign o_pix.valid = r_vld[NSTG-1];

endmodule

@@ rtl/core/iapm_chk.sv @@
// port-level checker for the inverse affine pixel mapper, bound to the top level
module iapm_chk import iapm_pkg::*; (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        i_in_ready,
    input logic                        i_out_valid,
    input logic                        i_out_ready,
    input logic signed [C_COORD_W-1:0] i_src_x,
    input logic signed [C_COORD_W-1:0] i_src_y,
    input logic                        i_inside_res,
    input logic [C_ADDR_W-1:0]         i_byte_address
);

    // stalled output transaction keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_byte_address)
            && $stable(i_src_x) && $stable(i_src_y) && $stable(i_inside_res))
        else $error("output transaction changed while stalled");

    // black pixels carry a zero address
    a_black_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_inside_res |-> i_byte_address == '0)
        else $error("outside pixel with nonzero address");

    // an inside pixel has nonnegative coordinates
    a_inside_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_inside_res |-> !i_src_x[C_COORD_W-1] && !i_src_y[C_COORD_W-1])
        else $error("inside pixel with negative coordinate");

    // the pipeline is empty right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> !i_out_valid)
        else $error("output transaction right after reset");

    // with the output stage empty every stage can advance, so input is taken
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input refused while the output stage is empty");

endmodule

bind inverse_affine_pixel_mapper_unit iapm_chk u_iapm_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_pix.valid),
    .i_in_ready     (i_pix.ready),
    .i_out_valid    (o_pix.valid),
    .i_out_ready    (o_pix.ready),
    .i_src_x        (o_pix.src_x),
    .i_src_y        (o_pix.src_y),
    .i_inside_res   (o_pix.inside_res),
    .i_byte_address (o_pix.byte_address)
);

@@ bench/inverse_affine_pixel_mapper_unit_tb.sv @@
// testbench for the inverse affine pixel mapper: scoreboard, stimulus, back-pressure and checks
module inverse_affine_pixel_mapper_unit_tb import iapm_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_DIM         = 4096;
    localparam int LATENCY         = 7;
    localparam int IDLE_PCT        = 22;
    localparam int HOLD_CYCLES     = 300;
    localparam int RANDOM_PHASES   = 12;
    localparam int ITEMS_PER_PHASE = 150;
    localparam int STEADY_PHASE    = 4;     // no idling on either side in this phase
    localparam int HOLD_PHASE      = 7;     // receiver holds off in this phase

    // one output transaction as the block presents it
    typedef struct packed {
        logic signed [C_COORD_W-1:0] src_x;
        logic signed [C_COORD_W-1:0] src_y;
        logic                        in_img;
        logic [C_ADDR_W-1:0]         addr;
    } mapped_px_t;

    // keeps a copy of the registers, predicts the mapped pixel of every
    // accepted coordinate and compares the block's output in order
    class mapper_scoreboard;
        logic signed [C_COEF_W-1:0] m00, m01, m10, m11;
        logic signed [C_COEF_W-1:0] shift_x, shift_y;
        logic [C_DIM_REG_W-1:0]     width, height;
        mapped_px_t                 expected_q[$];
        int                         errors;

        function new();
            m00     = C_ONE_Q16;
            m01     = '0;
            m10     = '0;
            m11     = C_ONE_Q16;
            shift_x = '0;
            shift_y = '0;
            width   = C_DIM_RST;
            height  = C_DIM_RST;
            errors  = 0;
        endfunction

        function void set_reg(t_cfg_idx idx, logic [C_COEF_W-1:0] data);
            case (idx)
                CFG_M00:    m00 = data;
                CFG_M01:    m01 = data;
                CFG_M10:    m10 = data;
                CFG_M11:    m11 = data;
                CFG_SHIFTX: shift_x = data;
                CFG_SHIFTY: shift_y = data;
                CFG_WIDTH:  width = data[C_DIM_REG_W-1:0];
                CFG_HEIGHT: height = data[C_DIM_REG_W-1:0];
                default: ;
            endcase
        endfunction

        function int eff_dim(logic [C_DIM_REG_W-1:0] d);
            return (d > MAX_DIM) ? MAX_DIM : int'(d);
        endfunction

        // trunc0((ka*ca + kb*cb) / 2^32 + dim/2), clamped to 16 bits, all exact
        function logic signed [C_COORD_W-1:0] map_axis(logic signed [C_COEF_W-1:0] ka,
                                                       logic signed [C_COEF_W-1:0] kb,
                                                       logic signed [99:0] ca,
                                                       logic signed [99:0] cb,
                                                       int dim);
            logic signed [99:0] a_w, b_w, acc, q;
            a_w = 100'(ka);
            b_w = 100'(kb);
            acc = a_w * ca + b_w * cb + (100'(dim) <<< 31);
            if (acc >= 0)
                q = acc >>> 32;
            else
                q = -((-acc) >>> 32);
            if (q > 32767)
                return 16'sh7fff;
            if (q < -32768)
                return 16'sh8000;
            return q[C_COORD_W-1:0];
        endfunction

        function void note_input(logic signed [C_COORD_W-1:0] x, logic signed [C_COORD_W-1:0] y);
            logic signed [99:0]          cx, cy;
            logic signed [C_COORD_W-1:0] sx, sy;
            mapped_px_t                  px;
            int                          w, h, sxi, syi;
            w  = eff_dim(width);
            h  = eff_dim(height);
            cx = 100'(x);
            cy = 100'(y);
            cx = (cx <<< 16) - (100'(w) <<< 15) + 100'(shift_x);
            cy = (cy <<< 16) - (100'(h) <<< 15) + 100'(shift_y);
            sx = map_axis(m00, m01, cx, cy, w);
            sy = map_axis(m10, m11, cx, cy, h);
            sxi = int'(sx);
            syi = int'(sy);
            px.src_x  = sx;
            px.src_y  = sy;
            px.in_img = (sxi >= 0) && (sxi < w) && (syi >= 0) && (syi < h);
            px.addr   = px.in_img ? C_ADDR_W'(C_BYTES_PER_PX * (syi * w + sxi)) : '0;
            expected_q.push_back(px);
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        task report(string msg);
            $display("%0t mismatch: %s", $time, msg);
            errors++;
        endtask

        task check_result(mapped_px_t got);
            mapped_px_t want;
            if (expected_q.size() == 0) begin
                report($sformatf("output with nothing expected, src %0d,%0d",
                                 got.src_x, got.src_y));
                return;
            end
            want = expected_q.pop_front();
            if (got.src_x !== want.src_x)
                report($sformatf("src_x %0d, want %0d", got.src_x, want.src_x));
            if (got.src_y !== want.src_y)
                report($sformatf("src_y %0d, want %0d", got.src_y, want.src_y));
            if (got.in_img !== want.in_img)
                report($sformatf("inside_res %b, want %b", got.in_img, want.in_img));
            if (got.addr !== want.addr)
                report($sformatf("byte_address %0d, want %0d", got.addr, want.addr));
        endtask
    endclass

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   i_cfg_we;
    logic [C_CFG_IDX_W-1:0] i_cfg_idx;
    logic [C_COEF_W-1:0]    i_cfg_data;

    iapm_in_if  pix_in ();
    iapm_out_if pix_out ();

    mapper_scoreboard sb = new();

    bit steady;         // both sides stop idling while set
    bit stall_token;    // toggled by the stimulus to ask for a long receiver hold-off
    bit stall_seen;     // last token the receiver acted on
    int cur_w, cur_h;   // effective image size, steers the coordinate ranges

    inverse_affine_pixel_mapper_unit #(
        .MAX_DIM (MAX_DIM)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_pix      (pix_in),
        .o_pix      (pix_out)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // hard stop in case a transaction never shows up
    initial begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

    // receiver: random ready, or a long hold-off counted here when asked for
    initial begin : receiver
        int hold_left;
        hold_left = 0;
        pix_out.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (!i_rst_n) begin
                pix_out.ready <= 1'b0;
            end else if (hold_left > 0) begin
                pix_out.ready <= 1'b0;
                hold_left--;
            end else if (stall_token != stall_seen) begin
                // pipeline fills up while the sender keeps offering
                stall_seen = stall_token;
                hold_left  = HOLD_CYCLES;
                pix_out.ready <= 1'b0;
            end else begin
                pix_out.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // every output transaction is checked against the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && pix_out.valid && pix_out.ready)
            sb.check_result(mapped_px_t'{pix_out.src_x, pix_out.src_y,
                                         pix_out.inside_res, pix_out.byte_address});
    end

    // one register write, the prediction follows at the same edge
    task automatic write_reg(input t_cfg_idx idx, input logic [C_COEF_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        sb.set_reg(idx, data);
    endtask

    // writes all eight registers; only called while nothing is in flight
    task automatic apply_config(input logic [C_COEF_W-1:0] k00, k01, k10, k11,
                                input logic [C_COEF_W-1:0] shx, shy, wd, ht);
        write_reg(CFG_M00, k00);
        write_reg(CFG_M01, k01);
        write_reg(CFG_M10, k10);
        write_reg(CFG_M11, k11);
        write_reg(CFG_SHIFTX, shx);
        write_reg(CFG_SHIFTY, shy);
        write_reg(CFG_WIDTH, wd);
        write_reg(CFG_HEIGHT, ht);
        i_cfg_we <= 1'b0;
        cur_w = (wd[C_DIM_REG_W-1:0] > MAX_DIM) ? MAX_DIM : int'(wd[C_DIM_REG_W-1:0]);
        cur_h = (ht[C_DIM_REG_W-1:0] > MAX_DIM) ? MAX_DIM : int'(ht[C_DIM_REG_W-1:0]);
    endtask

    // offers one coordinate, with random idle cycles ahead of it
    task automatic push_pixel(input logic signed [C_COORD_W-1:0] x,
                              input logic signed [C_COORD_W-1:0] y);
        while (!steady && ($urandom_range(99) < IDLE_PCT)) begin
            pix_in.valid <= 1'b0;
            @(posedge i_clk);
        end
        pix_in.valid  <= 1'b1;
        pix_in.dest_x <= x;
        pix_in.dest_y <= y;
        do
            @(posedge i_clk);
        while (!pix_in.ready);
        sb.note_input(x, y);
    endtask

    // sender pauses until every prediction has been matched, then lets the pipe settle
    task automatic wait_for_results();
        pix_in.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (LATENCY + 3) @(posedge i_clk);
    endtask

    // mostly moderate scale/rotation terms, sometimes the extremes or anything
    function automatic logic [C_COEF_W-1:0] rand_coef();
        case ($urandom_range(9))
            0: return $urandom;
            1: begin
                case ($urandom_range(2))
                    0:       return 32'h7fff_ffff;
                    1:       return 32'h8000_0000;
                    default: return 32'h0000_0000;
                endcase
            end
            default: return 32'(int'($urandom_range(4 * 65536)) - 2 * 65536);
        endcase
    endfunction

    // mostly within about a thousand pixels, now and then the full range
    function automatic logic [C_COEF_W-1:0] rand_shift();
        if ($urandom_range(7) == 0)
            return $urandom;
        return 32'(int'($urandom_range(1 << 27)) - (1 << 26));
    endfunction

    // image size, with zero, oversize and tiny images mixed in; upper bits are junk
    function automatic logic [C_COEF_W-1:0] rand_dim();
        int d;
        case ($urandom_range(19))
            0:       d = 0;
            1:       d = $urandom_range(8191, MAX_DIM + 1);
            2, 3, 4: d = $urandom_range(32, 1);
            default: d = $urandom_range(MAX_DIM, 1);
        endcase
        return ($urandom & 32'hffff_e000) | 32'(d);
    endfunction

    // coordinates near the image most of the time, otherwise any 16-bit value
    function automatic logic signed [C_COORD_W-1:0] rand_coord(input int dim);
        if ($urandom_range(99) < 15)
            return 16'($urandom);
        return 16'($urandom_range(dim + 16) - 8);
    endfunction

    initial begin : stimulus
        int phase_i, item_i;
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_idx     <= CFG_M00;
        i_cfg_data    <= '0;
        pix_in.valid  <= 1'b0;
        pix_in.dest_x <= '0;
        pix_in.dest_y <= '0;
        steady        <= 1'b0;
        stall_token   <= 1'b0;
        stall_seen    = 1'b0;
        cur_w         = MAX_DIM;
        cur_h         = MAX_DIM;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset values: identity, no shift, full size image; corners and coordinate extremes
        push_pixel(16'sd0, 16'sd0);
        push_pixel(16'sd2048, 16'sd2048);
        push_pixel(16'sd4095, 16'sd4095);
        push_pixel(16'sd4096, 16'sd100);
        push_pixel(-16'sd1, 16'sd5);
        push_pixel(16'sd5, -16'sd1);
        push_pixel(16'sh8000, 16'sh8000);
        push_pixel(16'sh7fff, 16'sh7fff);
        push_pixel(16'sh8000, 16'sh7fff);
        push_pixel(16'sh7fff, 16'sh8000);
        wait_for_results();

        // oversize width clamps to the maximum, zero height makes every pixel black
        apply_config(C_ONE_Q16, 32'h0, 32'h0, C_ONE_Q16, 32'h0, 32'h0,
                     32'hffff_ffff, 32'hffff_e000);
        push_pixel(16'sd0, 16'sd0);
        push_pixel(16'sd100, 16'sd100);
        push_pixel(16'sd4095, 16'sd0);
        wait_for_results();

        // extreme coefficients and shifts on a 1x1 image: saturation both ways
        apply_config(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff,
                     32'h7fff_ffff, 32'h8000_0000, 32'h1, 32'h1);
        push_pixel(16'sd0, 16'sd0);
        push_pixel(16'sh7fff, 16'sh8000);
        push_pixel(16'sh8000, 16'sh7fff);
        wait_for_results();

        // half scale on x, mirror on y, fractional shift: truncation toward zero
        apply_config(32'h0000_8000, 32'h0, 32'h0, 32'hffff_8000,
                     32'h0001_8000, 32'hfffe_8000, 32'd16, 32'd1);
        push_pixel(16'sd0, 16'sd0);
        push_pixel(16'sd15, 16'sd0);
        push_pixel(16'sd8, 16'sd0);
        push_pixel(16'sd31, 16'sd0);
        wait_for_results();

        // random phases, each with its own register setting
        for (phase_i = 0; phase_i < RANDOM_PHASES; phase_i++) begin
            steady <= (phase_i == STEADY_PHASE);
            apply_config(rand_coef(), rand_coef(), rand_coef(), rand_coef(),
                         rand_shift(), rand_shift(), rand_dim(), rand_dim());
            if (phase_i == HOLD_PHASE)
                stall_token <= ~stall_token;
            for (item_i = 0; item_i < ITEMS_PER_PHASE; item_i++)
                push_pixel(rand_coord(cur_w), rand_coord(cur_h));
            wait_for_results();
        end

        if (sb.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
